[hw/rtl/pffl_pkg.sv]
// Shared types and constants for the page frame free list allocator.
package pffl_pkg;

   localparam int DEF_NUM_BLOCKS = 65536;
   localparam int DEF_BLOCK_SIZE = 4096;
   localparam int ADDR_W         = 29;
   localparam int OUT_W          = 28;

   typedef enum logic [1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_FREE    = 2'd1,
      MODE_ADD     = 2'd2,
      MODE_RESERVE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_USED  = 2'd2,
      ST_BAD_RANGE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC,
      S_FREE,
      S_ADD_TAIL,
      S_ADD_WALK,
      S_RSV_CHK,
      S_RSV_SCAN,
      S_RSV_AFTER,
      S_RSV_SPLICE,
      S_RSV_CLR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] block_addr;
      logic [1:0]       status;
   } rsp_type;

   // Access strobes into the link and used-flag store.
   typedef struct packed {
      logic rd_en;
      logic link_wr;
      logic used_wr;
      logic used_data;
   } mem_ctl_type;

endpackage

[hw/rtl/page_frame_free_list_allocator.sv]
// Page frame allocator: link-table free list (LIFO for freed blocks), one request at a time.
// One request is taken at a time; req_stall stays high until its response is formed.
// Allocate and free each do one read, then one write, then hand off the response.
// Add region links the old tail to the region, then writes its links, one link write per cycle.
// Reserve reads the run at one block per cycle, then, unless the run starts at the
// head, scans the link table one entry per cycle for the predecessor (up to
// NUM_BLOCKS entries), then clears the run one block per cycle. All of this is set by
// the single port of the link/used store. After reset a clearing pass over all
// NUM_BLOCKS entries initializes the store; no request is accepted during it.
// BLOCK_SIZE must be a power of two.
module page_frame_free_list_allocator #(
   parameter int NUM_BLOCKS = pffl_pkg::DEF_NUM_BLOCKS,
   parameter int BLOCK_SIZE = pffl_pkg::DEF_BLOCK_SIZE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pffl_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pffl_pkg::rsp_type rsp_payload
);
   import pffl_pkg::*;

   localparam int AW          = $clog2(NUM_BLOCKS);
   localparam int LW          = $clog2(NUM_BLOCKS + 1);
   localparam int BLOCK_SHIFT = $clog2(BLOCK_SIZE);

   localparam logic [LW-1:0]     NIL      = LW'(NUM_BLOCKS);
   localparam logic [LW-1:0]     LAST_L   = LW'(NUM_BLOCKS - 1);
   localparam logic [AW-1:0]     LAST_A   = AW'(NUM_BLOCKS - 1);
   localparam logic [ADDR_W-1:0] NUM_A    = ADDR_W'(NUM_BLOCKS);
   localparam logic [ADDR_W-1:0] BLK_MASK = ADDR_W'(BLOCK_SIZE - 1);

   state_type     state_ff, state_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] s_ff, s_in;
   logic [AW-1:0] e_ff, e_in;
   logic [AW-1:0] pred_ff, pred_in;
   logic          at_head_ff, at_head_in;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] tail_ff, tail_in;
   rsp_type       res_ff, res_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   mem_ctl_type   mem_ctl;
   logic [AW-1:0] mem_addr;
   logic [LW-1:0] link_wdata;
   logic [LW-1:0] link_rd;
   logic          used_rd;

   logic [ADDR_W-1:0] idx_a, idx_b, end_idx;
   logic              b_aligned, range_ok;
   logic [LW-1:0]     rd_idx_next;
   logic              chk_fail, scan_hit;
   logic [LW-1:0]     new_head, new_tail;
   logic              rsp_load;

   pffl_store #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .AW         (AW),
      .LW         (LW)
   ) u_store (
      .clock      (clock),
      .mem_ctl    (mem_ctl),
      .mem_addr   (mem_addr),
      .link_wdata (link_wdata),
      .link_rdata (link_rd),
      .used_rdata (used_rd)
   );

   // Region bounds: an end address on a block boundary excludes that block.
   always_comb begin
      idx_a     = req_payload.addr_a >> BLOCK_SHIFT;
      idx_b     = req_payload.addr_b >> BLOCK_SHIFT;
      b_aligned = (req_payload.addr_b != '0) && ((req_payload.addr_b & BLK_MASK) == '0);
      end_idx   = idx_b - ADDR_W'(b_aligned);
      range_ok  = (idx_a <= end_idx) && (end_idx < NUM_A);
   end

   assign rd_idx_next = LW'(rd_idx_ff) + LW'(1);
   assign chk_fail    = used_rd || ((rd_idx_ff != e_ff) && (link_rd != rd_idx_next));
   assign scan_hit    = (link_rd == LW'(s_ff)) && !used_rd &&
                        ((rd_idx_ff < s_ff) || (rd_idx_ff > e_ff));

   always_comb begin
      new_head = at_head_ff ? link_rd : head_ff;
      new_tail = tail_ff;
      if ((tail_ff >= LW'(s_ff)) && (tail_ff <= LW'(e_ff))) begin
         new_tail = at_head_ff ? NIL : LW'(pred_ff);
      end
      if (new_head == NIL) begin
         new_tail = NIL;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      rd_vld_in  = 1'b0;
      rd_idx_in  = rd_idx_ff;
      s_in       = s_ff;
      e_in       = e_ff;
      pred_in    = pred_ff;
      at_head_in = at_head_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      res_in     = res_ff;
      mem_ctl    = '0;
      mem_addr   = cnt_ff[AW-1:0];
      link_wdata = NIL;

      unique case (state_ff)
         S_CLEAR: begin
            mem_ctl.link_wr = 1'b1;
            mem_ctl.used_wr = 1'b1;
            if (cnt_ff == LAST_L) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + LW'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               res_in.block_addr = '0;
               res_in.status     = ST_OK;
               s_in              = idx_a[AW-1:0];
               e_in              = end_idx[AW-1:0];
               unique case (mode_type'(req_payload.mode))
                  MODE_ALLOC: begin
                     if (head_ff == NIL) begin
                        res_in.status = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        mem_addr      = head_ff[AW-1:0];
                        state_in      = S_ALLOC;
                     end
                  end
                  MODE_FREE: begin
                     if (idx_a >= NUM_A) begin
                        res_in.status = ST_NOT_USED;
                        state_in      = S_DONE;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        mem_addr      = idx_a[AW-1:0];
                        state_in      = S_FREE;
                     end
                  end
                  MODE_ADD: begin
                     if (!range_ok) begin
                        res_in.status = ST_BAD_RANGE;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_ADD_TAIL;
                     end
                  end
                  MODE_RESERVE: begin
                     if (!range_ok) begin
                        res_in.status = ST_BAD_RANGE;
                        state_in      = S_DONE;
                     end else begin
                        cnt_in   = LW'(idx_a[AW-1:0]);
                        state_in = S_RSV_CHK;
                     end
                  end
               endcase
            end
         end
         S_ALLOC: begin
            mem_ctl.link_wr   = 1'b1;
            mem_ctl.used_wr   = 1'b1;
            mem_ctl.used_data = 1'b1;
            mem_addr          = head_ff[AW-1:0];
            head_in           = link_rd;
            if (link_rd == NIL) begin
               tail_in = NIL;
            end
            res_in.block_addr = OUT_W'({head_ff[AW-1:0], {BLOCK_SHIFT{1'b0}}});
            state_in          = S_DONE;
         end
         S_FREE: begin
            if (!used_rd) begin
               res_in.status = ST_NOT_USED;
            end else begin
               mem_ctl.link_wr = 1'b1;
               mem_ctl.used_wr = 1'b1;
               mem_addr        = s_ff;
               link_wdata      = head_ff;
               head_in         = LW'(s_ff);
               if (head_ff == NIL) begin
                  tail_in = LW'(s_ff);
               end
            end
            state_in = S_DONE;
         end
         S_ADD_TAIL: begin
            if (head_ff == NIL) begin
               head_in = LW'(s_ff);
            end
            if (tail_ff != NIL) begin
               mem_ctl.link_wr = 1'b1;
               mem_addr        = tail_ff[AW-1:0];
               link_wdata      = LW'(s_ff);
            end
            cnt_in   = LW'(s_ff);
            state_in = S_ADD_WALK;
         end
         S_ADD_WALK: begin
            mem_ctl.link_wr = 1'b1;
            if (cnt_ff == LW'(e_ff)) begin
               tail_in  = LW'(e_ff);
               state_in = S_DONE;
            end else begin
               link_wdata = cnt_ff + LW'(1);
               cnt_in     = cnt_ff + LW'(1);
            end
         end
         S_RSV_CHK: begin
            // read of block cnt is issued while block rd_idx is checked
            if (cnt_ff <= LW'(e_ff)) begin
               mem_ctl.rd_en = 1'b1;
               rd_idx_in     = cnt_ff[AW-1:0];
               rd_vld_in     = 1'b1;
               cnt_in        = cnt_ff + LW'(1);
            end
            if (rd_vld_ff) begin
               if (chk_fail) begin
                  res_in.status = ST_BAD_RANGE;
                  rd_vld_in     = 1'b0;
                  state_in      = S_DONE;
               end else if (rd_idx_ff == e_ff) begin
                  at_head_in = (head_ff == LW'(s_ff));
                  rd_vld_in  = 1'b0;
                  cnt_in     = '0;
                  state_in   = (head_ff == LW'(s_ff)) ? S_RSV_AFTER : S_RSV_SCAN;
               end
            end
         end
         S_RSV_SCAN: begin
            if (cnt_ff != NIL) begin
               mem_ctl.rd_en = 1'b1;
               rd_idx_in     = cnt_ff[AW-1:0];
               rd_vld_in     = 1'b1;
               cnt_in        = cnt_ff + LW'(1);
            end
            if (rd_vld_ff) begin
               if (scan_hit) begin
                  pred_in   = rd_idx_ff;
                  rd_vld_in = 1'b0;
                  state_in  = S_RSV_AFTER;
               end else if (rd_idx_ff == LAST_A) begin
                  res_in.status = ST_BAD_RANGE;
                  rd_vld_in     = 1'b0;
                  state_in      = S_DONE;
               end
            end
         end
         S_RSV_AFTER: begin
            mem_ctl.rd_en = 1'b1;
            mem_addr      = e_ff;
            state_in      = S_RSV_SPLICE;
         end
         S_RSV_SPLICE: begin
            if (!at_head_ff) begin
               mem_ctl.link_wr = 1'b1;
               mem_addr        = pred_ff;
               link_wdata      = link_rd;
            end
            head_in  = new_head;
            tail_in  = new_tail;
            cnt_in   = LW'(s_ff);
            state_in = S_RSV_CLR;
         end
         S_RSV_CLR: begin
            mem_ctl.link_wr   = 1'b1;
            mem_ctl.used_wr   = 1'b1;
            mem_ctl.used_data = 1'b1;
            if (cnt_ff == LW'(e_ff)) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + LW'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= rd_vld_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      s_ff       <= s_in;
      e_ff       <= e_in;
      pred_ff    <= pred_in;
      at_head_ff <= at_head_in;
      res_ff     <= res_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised without a finished request");

   a_head_tail : assert property (@(posedge clock) disable iff (reset)
      (head_ff == NIL) |-> (tail_ff == NIL))
      else $error("empty free list with a live tail");

   a_port_conflict : assert property (@(posedge clock) disable iff (reset)
      mem_ctl.rd_en |-> !(mem_ctl.link_wr || mem_ctl.used_wr))
      else $error("store read and write in one cycle");

   a_clear_quiet : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("response during clearing pass");

endmodule

[hw/rtl/pffl_store.sv]
// Link table and used-flag memories, one shared address, registered read.
module pffl_store #(
   parameter int NUM_BLOCKS = pffl_pkg::DEF_NUM_BLOCKS,
   parameter int AW         = $clog2(NUM_BLOCKS),
   parameter int LW         = $clog2(NUM_BLOCKS + 1)
) (
   input  logic                  clock,
   input  pffl_pkg::mem_ctl_type mem_ctl,
   input  logic [AW-1:0]         mem_addr,
   input  logic [LW-1:0]         link_wdata,
   output logic [LW-1:0]         link_rdata,
   output logic                  used_rdata
);
   import pffl_pkg::*;

   logic [LW-1:0] link_mem [NUM_BLOCKS];
   logic          used_mem [NUM_BLOCKS];
   logic [LW-1:0] link_rd_ff;
   logic          used_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.link_wr) begin
         link_mem[mem_addr] <= link_wdata;
      end
      if (mem_ctl.rd_en) begin
         link_rd_ff <= link_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.used_wr) begin
         used_mem[mem_addr] <= mem_ctl.used_data;
      end
      if (mem_ctl.rd_en) begin
         used_rd_ff <= used_mem[mem_addr];
      end
   end

   assign link_rdata = link_rd_ff;
   assign used_rdata = used_rd_ff;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the page frame free list allocator.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pffl_pkg::*;

   localparam int unsigned NB          = DEF_NUM_BLOCKS;
   localparam int unsigned BSZ         = DEF_BLOCK_SIZE;
   localparam int unsigned ADDR_MAX    = 2 ** ADDR_W - 1;
   localparam int unsigned POOL        = 1024;
   localparam int unsigned RAND_ITEMS  = 1125;
   localparam int unsigned QUIET_LIMIT = 1000000;

   typedef struct packed {
      req_type rq;
      bit      typed;
      rsp_type want;
   } vec_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // shadow of the allocator's state
   int unsigned nxt_tab [NB];
   bit          busy_tab [NB];
   int unsigned fl_head;
   int unsigned fl_tail;

   rsp_type     due_rsp [$];
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned next_fresh = 32;
   int unsigned heavy_ops = 0;
   bit          calm = 1'b0;

   page_frame_free_list_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("MISMATCH %s: got %0h expected %0h", what, got, want);
      mismatches++;
   endtask

   function automatic bit blk_range(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b,
                                    output int unsigned s, output int unsigned e);
      s = a / BSZ;
      e = b / BSZ;
      // an aligned end address excludes the block it starts
      if (b != 0 && b % BSZ == 0) e = e - 1;
      return s <= e && e < NB;
   endfunction

   function automatic bit run_is_free(input int unsigned s, input int unsigned e);
      int unsigned i;
      for (i = s; i <= e; i++)
         if (busy_tab[i] || (i < e && nxt_tab[i] != i + 1)) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int unsigned find_pred(input int unsigned s, input int unsigned e);
      int unsigned i;
      for (i = 0; i < NB; i++)
         if (nxt_tab[i] == s && !busy_tab[i] && (i < s || i > e)) return i;
      return NB;
   endfunction

   function automatic rsp_type frame_step(input req_type r);
      rsp_type     o;
      int unsigned s, e, i, blk, idx, pred, after;
      bit          at_head;
      o.block_addr = '0;
      o.status = ST_OK;
      case (r.mode)
         MODE_ALLOC: begin
            if (fl_head == NB) begin
               o.status = ST_EMPTY;
            end else begin
               blk = fl_head;
               fl_head = nxt_tab[blk];
               nxt_tab[blk] = NB;
               busy_tab[blk] = 1'b1;
               if (fl_head == NB) fl_tail = NB;
               o.block_addr = OUT_W'(blk * BSZ);
            end
         end
         MODE_FREE: begin
            idx = r.addr_a / BSZ;
            if (idx >= NB || !busy_tab[idx]) begin
               o.status = ST_NOT_USED;
            end else begin
               busy_tab[idx] = 1'b0;
               nxt_tab[idx] = fl_head;
               if (fl_head == NB) fl_tail = idx;
               fl_head = idx;
            end
         end
         MODE_ADD: begin
            if (!blk_range(r.addr_a, r.addr_b, s, e)) begin
               o.status = ST_BAD_RANGE;
            end else begin
               if (fl_head == NB) fl_head = s;
               if (fl_tail < NB) nxt_tab[fl_tail] = s;
               for (i = s; i < e; i++) nxt_tab[i] = i + 1;
               nxt_tab[e] = NB;
               fl_tail = e;
            end
         end
         default: begin
            pred = NB;
            if (!blk_range(r.addr_a, r.addr_b, s, e) || !run_is_free(s, e)) begin
               o.status = ST_BAD_RANGE;
            end else begin
               at_head = (fl_head == s);
               if (!at_head) pred = find_pred(s, e);
               if (!at_head && pred == NB) begin
                  o.status = ST_BAD_RANGE;
               end else begin
                  after = nxt_tab[e];
                  if (at_head) fl_head = after;
                  else nxt_tab[pred] = after;
                  if (fl_tail >= s && fl_tail <= e) fl_tail = at_head ? NB : pred;
                  if (fl_head == NB) fl_tail = NB;
                  for (i = s; i <= e; i++) begin
                     busy_tab[i] = 1'b1;
                     nxt_tab[i] = NB;
                  end
               end
            end
         end
      endcase
      return o;
   endfunction

   function automatic req_type gen_request();
      req_type     r;
      int unsigned s, e, k, pick, cost;
      bit          shaped;
      pick = $urandom_range(0, 99);
      shaped = 1'b0;
      r.mode = MODE_ALLOC;
      r.addr_a = ADDR_W'($urandom);
      r.addr_b = ADDR_W'($urandom);
      if (pick < 8) begin
         // noise: any mode, fields anywhere or loosely around the pool
         r.mode = 2'($urandom_range(0, 3));
         if (pick < 4) begin
            r.addr_a = ADDR_W'($urandom_range(0, POOL * BSZ - 1));
            r.addr_b = ADDR_W'(r.addr_a + $urandom_range(0, 8 * BSZ));
         end
      end else if (pick < 32) begin
         r.mode = MODE_ALLOC;
      end else if (pick < 52) begin
         r.mode = MODE_FREE;
         if (pick < 47) begin
            s = $urandom_range(0, POOL - 1);
            for (k = 0; k < 8 && !busy_tab[s]; k++) s = $urandom_range(0, POOL - 1);
            r.addr_a = ADDR_W'(s * BSZ + $urandom_range(0, BSZ - 1));
         end
      end else if (pick < 74) begin
         r.mode = MODE_ADD;
         shaped = 1'b1;
         k = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
         if (next_fresh + k > POOL) next_fresh = 32;
         s = next_fresh;
         e = s + k - 1;
         next_fresh += k;
         // reversed region
         if ($urandom_range(0, 11) == 0) begin
            k = s;
            s = e + 1;
            e = k - 1;
         end
      end else begin
         r.mode = MODE_RESERVE;
         shaped = 1'b1;
         s = fl_head;
         if (s == NB || $urandom_range(0, 5) == 0) begin
            s = $urandom_range(0, POOL - 1);
         end else begin
            for (k = $urandom_range(0, 5); k > 0 && nxt_tab[s] < NB; k--) s = nxt_tab[s];
         end
         e = s;
         for (k = $urandom_range(0, 3); k > 0 && e + 1 < NB && nxt_tab[e] == e + 1; k--)
            e++;
      end
      if (shaped) begin
         r.addr_a = ADDR_W'(s * BSZ + $urandom_range(0, BSZ - 1));
         r.addr_b = ADDR_W'($urandom_range(0, 1) ? (e + 1) * BSZ
                                                 : e * BSZ + $urandom_range(1, BSZ - 1));
      end
      // keep long walks and full-table scans to a handful
      cost = 0;
      if (r.mode == MODE_ADD && blk_range(r.addr_a, r.addr_b, s, e)) cost = e - s + 1;
      if (r.mode == MODE_RESERVE && blk_range(r.addr_a, r.addr_b, s, e) && run_is_free(s, e)
          && s != fl_head)
         cost = find_pred(s, e) + 1;
      if (cost > 4096) begin
         if (heavy_ops >= 4) r.mode = MODE_ALLOC;
         else heavy_ops++;
      end
      return r;
   endfunction

   task automatic put_req(input req_type rq, input bit typed, input rsp_type want);
      rsp_type guess;
      while (!calm && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      guess = frame_step(rq);
      due_rsp.push_back(typed ? want : guess);
   endtask

   function automatic vec_row_type row(input mode_type m, input int unsigned a,
                                       input int unsigned b, input bit typed,
                                       input int unsigned ea, input status_type es);
      vec_row_type v;
      v.rq.mode = m;
      v.rq.addr_a = ADDR_W'(a);
      v.rq.addr_b = ADDR_W'(b);
      v.typed = typed;
      v.want.block_addr = OUT_W'(ea);
      v.want.status = es;
      return v;
   endfunction

   always @(posedge clock) begin
      rsp_stall <= !calm && $urandom_range(0, 99) < 33;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_rsp.size() == 0) begin
            report_mismatch("response with no request pending",
                            32'(rsp_payload.block_addr), 0);
         end else begin
            want = due_rsp.pop_front();
            if (rsp_payload.block_addr !== want.block_addr)
               report_mismatch("block_addr", 32'(rsp_payload.block_addr),
                               32'(want.block_addr));
            if (rsp_payload.status !== want.status)
               report_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      vec_row_type plan [0:24];
      int unsigned n;
      for (n = 0; n < NB; n++) begin
         nxt_tab[n] = NB;
         busy_tab[n] = 1'b0;
      end
      fl_head = NB;
      fl_tail = NB;

      plan[0]  = row(MODE_ALLOC,   0, 0, 1, 0, ST_EMPTY);
      plan[1]  = row(MODE_FREE,    0, 0, 1, 0, ST_NOT_USED);
      plan[2]  = row(MODE_FREE,    NB * BSZ, 0, 1, 0, ST_NOT_USED);
      plan[3]  = row(MODE_FREE,    ADDR_MAX, ADDR_MAX, 1, 0, ST_NOT_USED);
      plan[4]  = row(MODE_ADD,     5 * BSZ, 3 * BSZ, 1, 0, ST_BAD_RANGE);
      plan[5]  = row(MODE_ADD,     0, ADDR_MAX, 1, 0, ST_BAD_RANGE);
      plan[6]  = row(MODE_RESERVE, ADDR_MAX, ADDR_MAX, 1, 0, ST_BAD_RANGE);
      plan[7]  = row(MODE_ADD,     0, 0, 0, 0, ST_OK);
      // pops the only free block
      plan[8]  = row(MODE_ALLOC,   0, 0, 0, 0, ST_OK);
      plan[9]  = row(MODE_ALLOC,   0, 0, 1, 0, ST_EMPTY);
      // free into an empty list, offset inside the block
      plan[10] = row(MODE_FREE,    123, 0, 0, 0, ST_OK);
      plan[11] = row(MODE_ADD,     BSZ, 4 * BSZ, 0, 0, ST_OK);
      plan[12] = row(MODE_ADD,     8 * BSZ + 123, 10 * BSZ + 5, 0, 0, ST_OK);
      plan[13] = row(MODE_ADD,     (NB - 1) * BSZ, NB * BSZ, 0, 0, ST_OK);
      plan[14] = row(MODE_RESERVE, 0, BSZ, 0, 0, ST_OK);
      plan[15] = row(MODE_RESERVE, 2 * BSZ, 4 * BSZ, 0, 0, ST_OK);
      // reserve of the tail
      plan[16] = row(MODE_RESERVE, (NB - 1) * BSZ, NB * BSZ - 1, 0, 0, ST_OK);
      plan[17] = row(MODE_RESERVE, 2 * BSZ, 2 * BSZ + 1, 1, 0, ST_BAD_RANGE);
      plan[18] = row(MODE_RESERVE, BSZ, 9 * BSZ + 7, 1, 0, ST_BAD_RANGE);
      // free block that is on no list: no predecessor
      plan[19] = row(MODE_RESERVE, 20 * BSZ, 20 * BSZ + 1, 1, 0, ST_BAD_RANGE);
      plan[20] = row(MODE_FREE,    NB * BSZ - 1, 0, 0, 0, ST_OK);
      plan[21] = row(MODE_ALLOC,   0, 0, 0, 0, ST_OK);
      plan[22] = row(MODE_RESERVE, BSZ, 2 * BSZ, 0, 0, ST_OK);
      // whole remaining list, head and tail both cleared
      plan[23] = row(MODE_RESERVE, 8 * BSZ, 11 * BSZ, 0, 0, ST_OK);
      plan[24] = row(MODE_ALLOC,   0, 0, 1, 0, ST_EMPTY);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < 25; n++) put_req(plan[n].rq, plan[n].typed, plan[n].want);

      for (n = 0; n < RAND_ITEMS; n++) begin
         calm = (n >= 500 && n < 700);
         if (n == 350) begin
            // hold off until every request in flight has answered
            req_valid <= 1'b0;
            @(posedge clock);
            while (due_rsp.size() != 0) @(posedge clock);
         end
         put_req(gen_request(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (due_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

[files.f]
hw/rtl/pffl_pkg.sv
hw/rtl/pffl_store.sv
hw/rtl/page_frame_free_list_allocator.sv
dv/tb_top.sv
